// ----- rtl/ple_pkg.sv -----
`default_nettype none

package ple_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // field widths of the stream beats
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_LOCATE   = 3'd3,
        OP_RETRIEVE = 3'd4,
        OP_NEXT     = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/ple_ram.sv -----
`default_nettype none

module ple_ram
    import ple_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   we,
    input  wire logic [IDX_W-1:0]       waddr,
    input  wire logic [VALUE_WIDTH-1:0] wdata,
    input  wire logic [IDX_W-1:0]       raddr,
    output logic      [VALUE_WIDTH-1:0] rdata
);

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address collision
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/positional_list_engine.sv -----
// Clear, next, unused op, empty locate, bad position, full: straight to the staged result.
// Retrieve reads the store first; insert shifts entries up from the end to the position and
// writes the gap; delete shifts entries down over the gap; locate scans from entry 0 to the
// first match, or to the end if absent. One item at a time, taken in idle once the result is
// in the output register. One read and one write port on the entry store set the walk rate.
// aresetn (synchronous, active low) empties the list and drops any pending result; store not cleared.
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // s_tdata: operation[2:0], item_value[34:3], position[39:35]
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // m_tdata: status[1:0], found_position[6:2], read_value[38:7],
    //          entry_total[43:39], zero fill [47:44]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,   // insert: move entries up, one read and one write per cycle
        S_INS_PUT,    // insert: drop the new value into the gap
        S_SHIFT_DN,   // delete: move entries down over the gap
        S_SCAN,       // locate: read and compare one entry per cycle
        S_FETCH,      // retrieve: read data lands
        S_DONE        // result staged, waiting for the output register
    } state_t;

    state_t                   state_reg, state_next;
    logic [OP_W-1:0]          op_reg, op_next;
    logic [VALUE_WIDTH-1:0]   val_reg, val_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic                     pend_reg, pend_next;   // read data in flight for dst_reg
    logic [IDX_W-1:0]         dst_reg, dst_next;
    logic [STAT_W-1:0]        res_stat_reg, res_stat_next;
    logic [POS_W-1:0]         res_found_reg, res_found_next;
    logic [VALUE_WIDTH-1:0]   res_read_reg, res_read_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]      m_tdata_reg, m_tdata_next;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [VALUE_WIDTH-1:0]   ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [VALUE_WIDTH-1:0]   ram_rdata;

    logic [OP_W-1:0]          in_op;
    logic [VALUE_WIDTH-1:0]   in_val;
    logic [POS_W-1:0]         in_pos;
    logic [CNT_W-1:0]         idx_dec;
    logic [CNT_W-1:0]         idx_inc;
    logic                     hit;

    assign in_op  = s_tdata[OP_W-1:0];
    assign in_val = s_tdata[OP_W +: VALUE_WIDTH];
    assign in_pos = s_tdata[OP_W + VALUE_WIDTH +: POS_W];

    // index decrement (insert), increment (delete and locate) and the locate compare
    assign idx_dec = idx_reg - 1'b1;
    assign idx_inc = idx_reg + 1'b1;
    assign hit     = (ram_rdata == val_reg);

    ple_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        dst_next       = dst_reg;
        res_stat_next  = res_stat_reg;
        res_found_next = res_found_reg;
        res_read_next  = res_read_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        ram_we         = 1'b0;
        ram_waddr      = dst_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                ram_raddr = in_pos[IDX_W-1:0];
                if (s_tvalid) begin
                    op_next        = in_op;
                    val_next       = in_val;
                    pos_next       = in_pos;
                    res_stat_next  = STAT_OK;
                    res_found_next = '0;
                    res_read_next  = '0;
                    pend_next      = 1'b0;
                    state_next     = S_DONE;
                    case (in_op)
                        OP_CLEAR: begin
                            cnt_next = '0;
                        end
                        OP_INSERT: begin
                            if (in_pos > cnt_reg) begin
                                res_stat_next = STAT_RANGE;
                            end else if (cnt_reg == CNT_W'(CAPACITY)) begin
                                res_stat_next = STAT_FULL;
                            end else begin
                                idx_next   = cnt_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_DELETE: begin
                            if (in_pos >= cnt_reg) begin
                                res_stat_next = STAT_RANGE;
                            end else begin
                                idx_next   = in_pos;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        OP_LOCATE: begin
                            if (cnt_reg == '0) begin
                                res_found_next = '0;
                            end else begin
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_RETRIEVE: begin
                            if (in_pos >= cnt_reg) begin
                                res_stat_next = STAT_RANGE;
                            end else begin
                                state_next = S_FETCH;
                            end
                        end
                        OP_NEXT: begin
                            if (in_pos >= cnt_reg) begin
                                res_stat_next  = STAT_RANGE;
                                res_found_next = cnt_reg;
                            end else begin
                                res_found_next = in_pos + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SHIFT_UP: begin
                ram_raddr = idx_dec[IDX_W-1:0];
                if (pend_reg) begin
                    ram_we = 1'b1;
                end
                if (idx_reg > pos_reg) begin
                    pend_next = 1'b1;
                    dst_next  = idx_reg[IDX_W-1:0];
                    idx_next  = idx_dec;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_INS_PUT;
                end
            end

            S_INS_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[IDX_W-1:0];
                ram_wdata  = val_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_DONE;
            end

            S_SHIFT_DN: begin
                ram_raddr = idx_inc[IDX_W-1:0];
                if (pend_reg) begin
                    ram_we = 1'b1;
                end
                if (idx_inc < cnt_reg) begin
                    pend_next = 1'b1;
                    dst_next  = idx_reg[IDX_W-1:0];
                    idx_next  = idx_inc;
                end else begin
                    pend_next  = 1'b0;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_SCAN: begin
                if (pend_reg && hit) begin
                    pend_next      = 1'b0;
                    res_found_next = POS_W'(dst_reg);
                    state_next     = S_DONE;
                end else if (idx_reg < cnt_reg) begin
                    pend_next = 1'b1;
                    dst_next  = idx_reg[IDX_W-1:0];
                    idx_next  = idx_inc;
                end else begin
                    pend_next      = 1'b0;
                    res_found_next = cnt_reg;
                    state_next     = S_DONE;
                end
            end

            S_FETCH: begin
                res_read_next = ram_rdata;
                state_next    = S_DONE;
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, cnt_reg, res_read_reg,
                                     res_found_reg, res_stat_reg};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg        <= op_next;
        val_reg       <= val_next;
        pos_reg       <= pos_next;
        idx_reg       <= idx_next;
        dst_reg       <= dst_next;
        res_stat_reg  <= res_stat_next;
        res_found_reg <= res_found_next;
        res_read_reg  <= res_read_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // count never passes the store size
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // writes only land at or below the live count
    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (CNT_W'(ram_waddr) <= cnt_reg))
        else $error("store write beyond the list");

    // an accepted beat always drops s_tready
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held across an accepted beat");

    // a new result only comes out of the staging state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid && !m_tready)) |-> $past(state_reg == S_DONE))
        else $error("result beat without a staged result");

    // the op code is held for the whole walk
    a_op_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE && $past(state_reg != S_IDLE)) |-> $stable(op_reg))
        else $error("operation changed mid-walk");

endmodule

`default_nettype wire

// ----- sim/tb_positional_list_engine.sv -----
`default_nettype none

module tb_positional_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    // opcodes the block must ignore: no change, zero result but for the entry total
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    // random traffic moods: grow the list, shrink it, or a bit of both
    localparam int MOOD_FILL  = 0;
    localparam int MOOD_DRAIN = 1;
    localparam int MOOD_MIXED = 2;

    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 300;  // long sink stall, fills the pipe
    localparam int DRAIN_CYCLES = 25;   // idle margin after the last result is checked

    // one expected result beat, checked field by field against m_tdata
    typedef struct packed {
        status_t         status;
        logic [4:0]      found;
        logic [31:0]     rd;
        logic [4:0]      total;
    } list_result_t;

    // one directed stimulus line; want is only used where known is set
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [31:0]      val;
        logic [POS_W-1:0] pos;
        logic             known;
        list_result_t     want;
    } stim_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // shadow copy of the list, advanced on every accepted input beat
    logic [31:0]  shadow_entries [CAPACITY];
    int           shadow_count = 0;
    list_result_t pending_results [$];

    int fail_count  = 0;
    bit quiet       = 1'b0;  // no idling on either side while set
    bit hold_armed  = 1'b0;  // stimulus asks the sink for one long stall
    bit hold_used   = 1'b0;
    int hold_left   = 0;

    positional_list_engine i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Expected result of one operation; updates the shadow list as the block would.
    function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [31:0] val,
                                                   input logic [POS_W-1:0] pos);
        list_result_t res;
        int i;
        int p;
        res.status = STAT_OK;
        res.found  = '0;
        res.rd     = '0;
        p = int'(pos);
        case (op)
            OP_CLEAR: begin
                shadow_count = 0;
            end
            OP_INSERT: begin
                // a bad position wins over a full list
                if (p > shadow_count) begin
                    res.status = STAT_RANGE;
                end else if (shadow_count >= CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    for (i = shadow_count; i > p; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[p] = val;
                    shadow_count++;
                end
            end
            OP_DELETE: begin
                if (p >= shadow_count) begin
                    res.status = STAT_RANGE;
                end else begin
                    for (i = p; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                end
            end
            OP_LOCATE: begin
                // first match wins; absent gives the count
                res.found = shadow_count[4:0];
                for (i = 0; i < shadow_count; i++) begin
                    if (shadow_entries[i] == val) begin
                        res.found = i[4:0];
                        break;
                    end
                end
            end
            OP_RETRIEVE: begin
                if (p >= shadow_count)
                    res.status = STAT_RANGE;
                else
                    res.rd = shadow_entries[p];
            end
            OP_NEXT: begin
                if (p >= shadow_count) begin
                    res.status = STAT_RANGE;
                    res.found  = shadow_count[4:0];
                end else begin
                    res.found = pos + 5'd1;
                end
            end
            default: begin
            end
        endcase
        res.total = shadow_count[4:0];
        return res;
    endfunction

    function automatic stim_row_t mk_row(input logic [OP_W-1:0] op, input logic [31:0] val,
                                         input logic [POS_W-1:0] pos, input logic known,
                                         input status_t st, input logic [4:0] found,
                                         input logic [31:0] rd, input logic [4:0] total);
        stim_row_t row;
        row.op          = op;
        row.val         = val;
        row.pos         = pos;
        row.known       = known;
        row.want.status = st;
        row.want.found  = found;
        row.want.rd     = rd;
        row.want.total  = total;
        return row;
    endfunction

    // Directed opening: empty-list errors, value extremes, shifts both ways,
    // first match, last entry for next, positions past the end, spare opcodes.
    // Rows with known set carry the result straight off the spec; the rest
    // go through the predictor.
    stim_row_t directed_rows [22] = '{
        mk_row(OP_RETRIEVE, 32'h0,        5'd0,  1'b1, STAT_RANGE, 5'd0, 32'h0,        5'd0),
        mk_row(OP_DELETE,   32'h0,        5'd0,  1'b1, STAT_RANGE, 5'd0, 32'h0,        5'd0),
        mk_row(OP_NEXT,     32'h0,        5'd0,  1'b1, STAT_RANGE, 5'd0, 32'h0,        5'd0),
        mk_row(OP_INSERT,   32'h1,        5'd1,  1'b1, STAT_RANGE, 5'd0, 32'h0,        5'd0),
        mk_row(OP_LOCATE,   32'h0,        5'd0,  1'b1, STAT_OK,    5'd0, 32'h0,        5'd0),
        mk_row(OP_INSERT,   32'h7FFFFFFF, 5'd0,  1'b1, STAT_OK,    5'd0, 32'h0,        5'd1),
        mk_row(OP_INSERT,   32'h80000000, 5'd0,  1'b1, STAT_OK,    5'd0, 32'h0,        5'd2),
        mk_row(OP_INSERT,   32'hFFFFFFFF, 5'd2,  1'b1, STAT_OK,    5'd0, 32'h0,        5'd3),
        mk_row(OP_INSERT,   32'h0,        5'd1,  1'b1, STAT_OK,    5'd0, 32'h0,        5'd4),
        mk_row(OP_RETRIEVE, 32'h0,        5'd0,  1'b1, STAT_OK,    5'd0, 32'h80000000, 5'd4),
        mk_row(OP_RETRIEVE, 32'h0,        5'd3,  1'b1, STAT_OK,    5'd0, 32'hFFFFFFFF, 5'd4),
        mk_row(OP_INSERT,   32'hFFFFFFFF, 5'd0,  1'b0, STAT_OK,    5'd0, 32'h0,        5'd0),
        mk_row(OP_LOCATE,   32'hFFFFFFFF, 5'd0,  1'b0, STAT_OK,    5'd0, 32'h0,        5'd0),
        mk_row(OP_LOCATE,   32'h00012345, 5'd0,  1'b0, STAT_OK,    5'd0, 32'h0,        5'd0),
        mk_row(OP_NEXT,     32'h0,        5'd4,  1'b0, STAT_OK,    5'd0, 32'h0,        5'd0),
        mk_row(OP_NEXT,     32'h0,        5'd31, 1'b0, STAT_OK,    5'd0, 32'h0,        5'd0),
        mk_row(OP_RETRIEVE, 32'h0,        5'd31, 1'b0, STAT_OK,    5'd0, 32'h0,        5'd0),
        mk_row(OP_DELETE,   32'h0,        5'd31, 1'b0, STAT_OK,    5'd0, 32'h0,        5'd0),
        mk_row(OP_DELETE,   32'h0,        5'd0,  1'b0, STAT_OK,    5'd0, 32'h0,        5'd0),
        mk_row(OP_SPARE6,   32'h12345678, 5'd2,  1'b1, STAT_OK,    5'd0, 32'h0,        5'd4),
        mk_row(OP_SPARE7,   32'hFFFFFFFF, 5'd31, 1'b1, STAT_OK,    5'd0, 32'h0,        5'd4),
        mk_row(OP_CLEAR,    32'hFFFFFFFF, 5'd31, 1'b1, STAT_OK,    5'd0, 32'h0,        5'd0)
    };

    // source side idles ~37% of cycles unless quiet
    task automatic source_gap();
        while (!quiet && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // drive one input beat until taken, then queue its expected result
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [31:0] val,
                             input logic [POS_W-1:0] pos, input logic known,
                             input list_result_t want);
        list_result_t predicted;
        source_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, val, op};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_list_op(op, val, pos);
        pending_results.push_back(known ? want : predicted);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input int mood);
        int r;
        int ins_w;
        int del_w;
        int rest;
        r = $urandom_range(99);
        case (mood)
            MOOD_FILL:  begin ins_w = 55; del_w = 8;  end
            MOOD_DRAIN: begin ins_w = 10; del_w = 45; end
            default:    begin ins_w = 25; del_w = 20; end
        endcase
        rest = 96 - ins_w - del_w;
        if (r < 2) return OP_CLEAR;
        if (r == 2) return OP_SPARE6;
        if (r == 3) return OP_SPARE7;
        r -= 4;
        if (r < ins_w) return OP_INSERT;
        r -= ins_w;
        if (r < del_w) return OP_DELETE;
        r -= del_w;
        if (r < rest / 3) return OP_LOCATE;
        if (r < 2 * rest / 3) return OP_RETRIEVE;
        return OP_NEXT;
    endfunction

    // values: often one already in the list (hits and duplicates), some extremes
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40 && shadow_count > 0)
            return shadow_entries[$urandom_range(shadow_count - 1)];
        if (r < 50) begin
            case ($urandom_range(3))
                0:       return 32'h0;
                1:       return 32'h7FFFFFFF;
                2:       return 32'h80000000;
                default: return 32'hFFFFFFFF;
            endcase
        end
        return $urandom;
    endfunction

    // positions: mostly legal for the op, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] pick_pos(input logic [OP_W-1:0] op);
        if ($urandom_range(99) < 15)
            return POS_W'($urandom_range(31));
        if (op == OP_INSERT)
            return POS_W'($urandom_range(shadow_count));
        if (shadow_count > 0)
            return POS_W'($urandom_range(shadow_count - 1));
        return POS_W'($urandom_range(31));
    endfunction

    initial begin : stimulus
        int k;
        int mood;
        logic [OP_W-1:0] op;
        list_result_t none;
        none = '0;
        mood = MOOD_FILL;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k])
            send_beat(directed_rows[k].op, directed_rows[k].val, directed_rows[k].pos,
                      directed_rows[k].known, directed_rows[k].want);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 40 == 0)
                mood = $urandom_range(2);
            if (k == 150)
                hold_armed = 1'b1;
            quiet = (k >= 300 && k < 380);
            op = pick_op(mood);
            send_beat(op, pick_value(), pick_pos(op), 1'b0, none);
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    task automatic check_beat(input logic [M_DATA_W-1:0] beat);
        list_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing expected", beat));
            return;
        end
        want = pending_results.pop_front();
        if (beat[1:0] != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", beat[1:0], want.status));
        if (beat[6:2] != want.found)
            report_mismatch($sformatf("found_position %0d, expected %0d",
                                      beat[6:2], want.found));
        if (beat[38:7] != want.rd)
            report_mismatch($sformatf("read_value %h, expected %h", beat[38:7], want.rd));
        if (beat[43:39] != want.total)
            report_mismatch($sformatf("entry_total %0d, expected %0d",
                                      beat[43:39], want.total));
        if (beat[47:44] != 4'h0)
            report_mismatch($sformatf("fill bits %h not zero", beat[47:44]));
    endtask

    // Sink: checks each taken beat, idles at random, and once holds m_tready low
    // in one long stall so the block backs up and drops s_tready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_beat(m_tdata);
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_used) begin
            m_tready  <= 1'b0;
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 37);
        end
    end

    // watchdog; a normal run needs well under a tenth of this
    initial begin : watchdog
        #(2_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
